// ===== hw/rtl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

    // queue capacity and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int DATA_W = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // wrap a position below twice the depth back into the ring
    function automatic t_idx wrap_idx(input logic [SUM_W-1:0] pos);
        logic [SUM_W-1:0] adj;
        adj = (pos >= SUM_W'(DEPTH)) ? (pos - SUM_W'(DEPTH)) : pos;
        return adj[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a ring buffer of
// DEPTH entries (dq_pkg). A command is taken when start is high and busy is
// low; busy never rises, so one command can be issued every cycle. Each
// command gives exactly one result, shown for one cycle with o_valid high in
// the cycle after the command was taken: the store is a single-port RAM with
// a registered read, and the head index and count are updated at the edge
// that takes the command. Results cannot be held off, so a receiver must
// capture every o_valid cycle. Status 0 is ok, 1 is a pop or peek on an
// empty queue, 2 is a push onto a full queue; in both error cases nothing
// changes and o_value_out is zero, as it is for pushes and unused codes.

module double_ended_queue
    import dq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_value_in,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_empty_res,
    output logic [1:0]               o_status
);

    t_idx            r_head, n_head;
    t_cnt            r_count, n_count;
    logic            r_valid;
    logic            r_rd_sel, n_rd_sel;
    logic [1:0]      r_status, n_status;

    logic            fire;
    logic            is_empty, is_full;
    logic            mem_we;
    t_idx            mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    t_idx            head_dec, head_inc, tail_slot, back_slot;

    assign busy = 1'b0;
    assign fire = start & ~busy;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));

    // ring positions around the head
    assign head_dec  = (r_head == '0) ? t_idx'(DEPTH - 1) : (r_head - t_idx'(1));
    assign head_inc  = wrap_idx(SUM_W'(r_head) + SUM_W'(1));
    assign tail_slot = wrap_idx(SUM_W'(r_head) + SUM_W'(r_count));
    assign back_slot = wrap_idx(SUM_W'(r_head) + SUM_W'(r_count) - SUM_W'(1));

    // command decode: pointer update, store access and result status
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rd_sel = 1'b0;
        n_status = ST_OK;
        mem_we   = 1'b0;
        mem_addr = r_head;
        case (i_cmd)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we   = fire;
                    mem_addr = head_dec;
                    n_head   = head_dec;
                    n_count  = r_count + t_cnt'(1);
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we   = fire;
                    mem_addr = tail_slot;
                    n_count  = r_count + t_cnt'(1);
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_addr = r_head;
                    n_rd_sel = 1'b1;
                    if (i_cmd == CMD_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - t_cnt'(1);
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_addr = back_slot;
                    n_rd_sel = 1'b1;
                    if (i_cmd == CMD_POP_BACK) begin
                        n_count = r_count - t_cnt'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // entry store
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_value_in),
        .o_rdata (mem_rdata)
    );

    // control state and result tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_rd_sel <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_valid <= fire;
            if (fire) begin
                r_head   <= n_head;
                r_count  <= n_count;
                r_rd_sel <= n_rd_sel;
                r_status <= n_status;
            end
        end
    end

    // result transaction, in the cycle after the command
    assign o_valid     = r_valid;
    assign o_value_out = r_rd_sel ? mem_rdata : '0;
    assign o_count     = r_count;
    assign o_empty_res = (r_count == '0);
    assign o_status    = r_status;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("command taken without a result in the next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full rejection while not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_empty_res && o_value_out == '0))
        else $error("empty error with data or entries");
`endif

endmodule

// ===== hw/rtl/dq_ram.sv =====
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
